// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define TCPK_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define TCPK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define TCPK_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/tcpk_pkg.sv
`default_nettype none

package tcpk_pkg;

    localparam int W_WIDTH   = 16;
    localparam int VAL_W     = 16;
    localparam int X_W       = 18;
    localparam int LEN_W     = 17;
    localparam int MAG_W     = 18;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int NUM_W     = SQ_W + 1;
    localparam int OPND_W    = 38;
    localparam int REM_W     = 22;
    localparam int DIVR_W    = W_WIDTH + 1;
    localparam int RES_W     = SQ_W;
    localparam int ROOT_W    = OPND_W / 2;
    localparam int SQRT_STEPS = OPND_W / 2;
    localparam int DIV_STEPS  = SQ_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int TDATA_W   = 72;

    localparam logic [W_WIDTH-1:0] PLANE_WIDTH_RST = 16'd7200;
    localparam logic [LEN_W-1:0]   LEN_MAX = '1;
    localparam logic [X_W-1:0]     X_MAX   = {1'b0, {(X_W-1){1'b1}}};
    localparam logic [X_W-1:0]     X_MIN   = {1'b1, {(X_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_X = 2'd0,
        MODE_Y = 2'd1,
        MODE_A = 2'd2,
        MODE_B = 2'd3
    } mode_t;

    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_XY_SQ_X,
        ST_XY_SQ_Y,
        ST_XY_SQ_D,
        ST_XY_ROOT_A,
        ST_XY_WAIT_A,
        ST_XY_ROOT_B,
        ST_XY_WAIT_B,
        ST_CD_SQ_A,
        ST_CD_SQ_B,
        ST_CD_SQ_W,
        ST_CD_NUM,
        ST_CD_DIV,
        ST_CD_WAIT_Q,
        ST_CD_SQ_X,
        ST_CD_XX,
        ST_CD_WAIT_Y,
        ST_DONE
    } state_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [RES_W-1:0] r);
        sat_len = (r > RES_W'(LEN_MAX)) ? LEN_MAX : r[LEN_W-1:0];
    endfunction

    // quotient magnitude plus sign -> saturated signed x
    function automatic logic [X_W-1:0] sat_x(input logic neg, input logic [RES_W-1:0] mag);
        logic [X_W-1:0] m;
        m = mag[X_W-1:0];
        if (neg) begin
            sat_x = (mag > RES_W'({1'b1, {(X_W-1){1'b0}}})) ? X_MIN : (~m + 1'b1);
        end else begin
            sat_x = (mag > RES_W'(X_MAX)) ? X_MAX : m;
        end
    endfunction

endpackage

`default_nettype wire

// File: src/tcpk_sq.sv
`default_nettype none

// Registered squarer shared by every product in the block.
module tcpk_sq import tcpk_pkg::*; (
    input  wire logic             aclk,
    input  wire logic [MAG_W-1:0] op,
    output logic      [SQ_W-1:0]  sq
);

    logic [SQ_W-1:0] sq_reg;

    always_ff @(posedge aclk) begin
        sq_reg <= SQ_W'(op) * SQ_W'(op);
    end

    assign sq = sq_reg;

endmodule

`default_nettype wire

// File: src/tcpk_iter.sv
`default_nettype none

// Shared restoring unit: one root digit or one quotient bit per cycle.
module tcpk_iter import tcpk_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire iter_ctrl_t        ctrl,
    input  wire logic [OPND_W-1:0] opnd,
    input  wire logic [DIVR_W-1:0] divisor,
    output logic                   done,
    output logic      [RES_W-1:0]  res
);

    iter_op_t          op_reg, op_next;
    logic [OPND_W-1:0] opnd_reg, opnd_next;
    logic [DIVR_W-1:0] div_reg, div_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [RES_W-1:0]  res_reg, res_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic              last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        op_reg   <= op_next;
        opnd_reg <= opnd_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    always_comb begin
        if (op_reg == OP_SQRT) begin
            rem_sh = {rem_reg[REM_W-3:0], opnd_reg[OPND_W-1 -: 2]};
            trial  = {1'b0, res_reg[ROOT_W-1:0], 2'b01};
            last   = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
        end else begin
            rem_sh = {rem_reg[REM_W-2:0], opnd_reg[OPND_W-1]};
            trial  = REM_W'(div_reg);
            last   = (cnt_reg == CNT_W'(DIV_STEPS - 1));
        end
        ge = (rem_sh >= trial);

        op_next   = op_reg;
        opnd_next = opnd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (ctrl.start) begin
            op_next   = ctrl.op;
            opnd_next = opnd;
            div_next  = divisor;
            rem_next  = '0;
            res_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            res_next  = {res_reg[RES_W-2:0], ge};
            opnd_next = (op_reg == OP_SQRT) ? {opnd_reg[OPND_W-3:0], 2'b00}
                                            : {opnd_reg[OPND_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// File: src/two_cord_plotter_kinematics_core.sv
`default_nettype none

// Two-cord plotter kinematics. Holds the pen position both as x,y and as the two
// cord lengths a,b (units of 1/16 mm). Each s_ transfer sets one coordinate
// (s_tuser: 0 x, 1 y, 2 cord a, 3 cord b; s_tdata: value) and yields one m_
// transfer with the full updated position; m_tuser flags cord lengths that give
// no real y (y is then 0). x saturates to its 18-bit signed range and cords to
// 131071. The shared root/divide unit retires one root digit (19 per root) or one
// quotient bit (36 per division) each cycle. s_tready is low while an item is in
// work; a finished result waits in the output register while the next item is
// taken. plane_width is written through cfg_valid/cfg_data; the user is to write
// it only while the block is idle, which the block itself does not enforce
// (reset value 7200).
module two_cord_plotter_kinematics_core import tcpk_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [W_WIDTH-1:0]  cfg_data,     // plane_width
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [15:0]         s_tdata,      // [15:0] value
    input  wire logic [1:0]          s_tuser,      // [1:0] mode
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata,      // pos_x, pos_y, cord_a, cord_b, pad
    output logic [0:0]               m_tuser       // [0] unreachable
);

    state_t             state_reg, state_next;
    logic [W_WIDTH-1:0] width_reg;
    logic [X_W-1:0]     x_reg, x_next;
    logic [LEN_W-1:0]   y_reg, y_next;
    logic [LEN_W-1:0]   a_reg, a_next;
    logic [LEN_W-1:0]   b_reg, b_next;
    logic               unreach_reg, unreach_next;
    logic [SQ_W-1:0]    t0_reg, t0_next;
    logic [SQ_W-1:0]    t1_reg, t1_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic               m_valid_reg, m_valid_next;
    logic [TDATA_W-1:0] m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;

    logic [MAG_W-1:0]   sq_op;
    logic [SQ_W-1:0]    sq_val;
    iter_ctrl_t         iter_ctrl;
    logic [OPND_W-1:0]  iter_opnd;
    logic [DIVR_W-1:0]  iter_div;
    logic               iter_done;
    logic [RES_W-1:0]   iter_res;

    logic [MAG_W-1:0]   x_mag;
    logic [X_W:0]       dx;
    logic [X_W:0]       dx_mag;
    logic [RES_W-1:0]   num_mag;
    mode_t              in_mode;

    tcpk_sq u_sq (
        .aclk (aclk),
        .op   (sq_op),
        .sq   (sq_val)
    );

    tcpk_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (iter_ctrl),
        .opnd    (iter_opnd),
        .divisor (iter_div),
        .done    (iter_done),
        .res     (iter_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= PLANE_WIDTH_RST;
            x_reg       <= '0;
            y_reg       <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_valid) begin
                width_reg <= cfg_data;
            end
            x_reg       <= x_next;
            y_reg       <= y_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            m_valid_reg <= m_valid_next;
        end
        unreach_reg <= unreach_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        num_reg     <= num_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    assign in_mode = mode_t'(s_tuser);
    assign x_mag   = x_reg[X_W-1] ? (~x_reg + 1'b1) : x_reg;
    assign dx      = {{(X_W+1-W_WIDTH){1'b0}}, width_reg} - {x_reg[X_W-1], x_reg};
    assign dx_mag  = dx[X_W] ? (~dx + 1'b1) : dx;
    assign num_mag = num_reg[NUM_W-1] ? RES_W'(~num_reg + 1'b1) : RES_W'(num_reg);

    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        unreach_next = unreach_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        num_next     = num_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg && !m_tready;
        sq_op        = '0;
        iter_ctrl    = '{start: 1'b0, op: OP_SQRT};
        iter_opnd    = '0;
        iter_div     = {width_reg, 1'b0};

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unreach_next = 1'b0;
                    case (in_mode)
                        MODE_X: begin
                            x_next     = X_W'(s_tdata);
                            state_next = ST_XY_SQ_X;
                        end
                        MODE_Y: begin
                            y_next     = LEN_W'(s_tdata);
                            state_next = ST_XY_SQ_X;
                        end
                        MODE_A: begin
                            a_next     = LEN_W'(s_tdata);
                            state_next = ST_CD_SQ_A;
                        end
                        default: begin
                            b_next     = LEN_W'(s_tdata);
                            state_next = ST_CD_SQ_A;
                        end
                    endcase
                end
            end
            // cords from x,y
            ST_XY_SQ_X: begin
                sq_op      = x_mag;
                state_next = ST_XY_SQ_Y;
            end
            ST_XY_SQ_Y: begin
                sq_op      = MAG_W'(y_reg);
                t0_next    = sq_val;
                state_next = ST_XY_SQ_D;
            end
            ST_XY_SQ_D: begin
                sq_op      = dx_mag[MAG_W-1:0];
                t1_next    = sq_val;
                state_next = ST_XY_ROOT_A;
            end
            ST_XY_ROOT_A: begin
                iter_ctrl  = '{start: 1'b1, op: OP_SQRT};
                iter_opnd  = OPND_W'({1'b0, t0_reg} + {1'b0, t1_reg});
                t0_next    = sq_val;
                state_next = ST_XY_WAIT_A;
            end
            ST_XY_WAIT_A: begin
                if (iter_done) begin
                    a_next     = sat_len(iter_res);
                    state_next = ST_XY_ROOT_B;
                end
            end
            ST_XY_ROOT_B: begin
                iter_ctrl  = '{start: 1'b1, op: OP_SQRT};
                iter_opnd  = OPND_W'({1'b0, t0_reg} + {1'b0, t1_reg});
                state_next = ST_XY_WAIT_B;
            end
            ST_XY_WAIT_B: begin
                if (iter_done) begin
                    b_next     = sat_len(iter_res);
                    state_next = ST_DONE;
                end
            end
            // x,y from cords
            ST_CD_SQ_A: begin
                sq_op      = MAG_W'(a_reg);
                state_next = ST_CD_SQ_B;
            end
            ST_CD_SQ_B: begin
                sq_op      = MAG_W'(b_reg);
                t0_next    = sq_val;
                state_next = ST_CD_SQ_W;
            end
            ST_CD_SQ_W: begin
                sq_op      = MAG_W'(width_reg);
                t1_next    = sq_val;
                state_next = ST_CD_NUM;
            end
            ST_CD_NUM: begin
                num_next   = NUM_W'(sq_val) + NUM_W'(t0_reg) - NUM_W'(t1_reg);
                state_next = ST_CD_DIV;
            end
            ST_CD_DIV: begin
                if (width_reg == '0) begin
                    // no anchor spacing: x is taken as zero
                    x_next     = '0;
                    state_next = ST_CD_SQ_X;
                end else begin
                    iter_ctrl  = '{start: 1'b1, op: OP_DIV};
                    iter_opnd  = {num_mag, {(OPND_W-RES_W){1'b0}}};
                    state_next = ST_CD_WAIT_Q;
                end
            end
            ST_CD_WAIT_Q: begin
                if (iter_done) begin
                    x_next     = sat_x(num_reg[NUM_W-1], iter_res);
                    state_next = ST_CD_SQ_X;
                end
            end
            ST_CD_SQ_X: begin
                sq_op      = x_mag;
                state_next = ST_CD_XX;
            end
            ST_CD_XX: begin
                if (t0_reg < sq_val) begin
                    y_next       = '0;
                    unreach_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    iter_ctrl  = '{start: 1'b1, op: OP_SQRT};
                    iter_opnd  = OPND_W'(t0_reg - sq_val);
                    state_next = ST_CD_WAIT_Y;
                end
            end
            ST_CD_WAIT_Y: begin
                if (iter_done) begin
                    y_next     = iter_res[LEN_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(TDATA_W-X_W-3*LEN_W){1'b0}},
                                    b_reg, a_reg, y_reg, x_reg};
                    m_user_next  = unreach_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

`default_nettype wire

// File: src/tcpk_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tcpk_checker import tcpk_pkg::*; (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [0:0]         m_tuser
);

    logic s_xfer;
    logic m_stall;
    logic m_unreach;
    logic m_y_zero;

    assign s_xfer    = s_tvalid && s_tready;
    assign m_stall   = m_tvalid && !m_tready;
    assign m_unreach = m_tvalid && m_tuser[0];
    assign m_y_zero  = (m_tdata[X_W +: LEN_W] == '0);

    `TCPK_ASSERT_NEXT_ALWAYS(a_rst_no_out, aclk, !aresetn, !m_tvalid)
    `TCPK_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_xfer, !s_tready)
    `TCPK_ASSERT_IMPL(a_unreach_y0, aclk, aresetn, m_unreach, m_y_zero)
    `TCPK_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_stall, m_tvalid && $stable({m_tuser, m_tdata}))

endmodule

bind two_cord_plotter_kinematics_core tcpk_checker u_tcpk_checker (.*);

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

module tb;
    import tcpk_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 150;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 150;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 50;
    localparam int Y_LSB        = X_W;
    localparam int A_LSB        = X_W + LEN_W;
    localparam int B_LSB        = X_W + 2 * LEN_W;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic [LEN_W-1:0]      y;
        logic [LEN_W-1:0]      a;
        logic [LEN_W-1:0]      b;
        logic                  unr;
    } pen_pos_t;

    typedef struct {
        bit                  new_w;
        logic [W_WIDTH-1:0]  w;
        mode_t               mode;
        logic [VAL_W-1:0]    val;
        bit                  typed;
        pen_pos_t            want;
    } plan_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [W_WIDTH-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [0:0]           m_tuser;

    // shadow of the block's state
    logic [W_WIDTH-1:0]     plane_w;
    logic signed [X_W-1:0]  pen_x;
    logic [LEN_W-1:0]       pen_y;
    logic [LEN_W-1:0]       cord_a_len;
    logic [LEN_W-1:0]       cord_b_len;

    pen_pos_t expected_positions[$];

    int  positions_sent = 0;
    int  positions_checked = 0;
    int  unreachable_seen = 0;
    int  mismatch_count = 0;
    int  widths_used = 0;
    int  idle_cycles = 0;
    bit  rx_throttle = 1'b1;
    bit  tx_throttle = 1'b0;
    bit  long_hold_done = 1'b0;

    // directed rows; typed expectations only where they are obvious
    plan_row_t plan [0:22] = '{
        '{1'b0, 16'd0,     MODE_X, 16'd0,     1'b1, '{18'd0, 17'd0, 17'd0, 17'd7200, 1'b0}},
        '{1'b0, 16'd0,     MODE_Y, 16'd0,     1'b1, '{18'd0, 17'd0, 17'd0, 17'd7200, 1'b0}},
        '{1'b0, 16'd0,     MODE_X, 16'hFFFF,  1'b1,
            '{18'd65535, 17'd0, 17'd65535, 17'd58335, 1'b0}},
        '{1'b0, 16'd0,     MODE_Y, 16'hFFFF,  1'b0, '0},
        '{1'b0, 16'd0,     MODE_X, 16'd7200,  1'b0, '0},
        '{1'b0, 16'd0,     MODE_A, 16'd0,     1'b0, '0},
        '{1'b0, 16'd0,     MODE_B, 16'd0,     1'b1, '{18'd3600, 17'd0, 17'd0, 17'd0, 1'b1}},
        '{1'b0, 16'd0,     MODE_A, 16'hFFFF,  1'b0, '0},
        '{1'b0, 16'd0,     MODE_B, 16'hFFFF,  1'b0, '0},
        '{1'b0, 16'd0,     MODE_A, 16'd3600,  1'b0, '0},
        '{1'b1, 16'd16,    MODE_B, 16'd0,     1'b1, '{X_MAX, 17'd0, 17'd3600, 17'd0, 1'b1}},
        '{1'b0, 16'd0,     MODE_Y, 16'hFFFF,  1'b1, '{X_MAX, 17'd65535, LEN_MAX, LEN_MAX, 1'b0}},
        '{1'b0, 16'd0,     MODE_A, 16'd0,     1'b1, '{X_MIN, 17'd0, 17'd0, LEN_MAX, 1'b1}},
        '{1'b0, 16'd0,     MODE_Y, 16'd0,     1'b1, '{X_MIN, 17'd0, LEN_MAX, LEN_MAX, 1'b0}},
        '{1'b1, 16'd0,     MODE_A, 16'd5,     1'b1, '{18'd0, 17'd5, 17'd5, LEN_MAX, 1'b0}},
        '{1'b0, 16'd0,     MODE_B, 16'd100,   1'b1, '{18'd0, 17'd5, 17'd5, 17'd100, 1'b0}},
        '{1'b0, 16'd0,     MODE_X, 16'd300,   1'b0, '0},
        '{1'b1, 16'hFFFF,  MODE_X, 16'hFFFF,  1'b1,
            '{18'd65535, 17'd5, 17'd65535, 17'd5, 1'b0}},
        '{1'b0, 16'd0,     MODE_A, 16'hFFFF,  1'b0, '0},
        '{1'b0, 16'd0,     MODE_B, 16'hFFFF,  1'b0, '0},
        '{1'b0, 16'd0,     MODE_B, 16'd0,     1'b0, '0},
        '{1'b0, 16'd0,     MODE_Y, 16'd12345, 1'b0, '0},
        '{1'b0, 16'd0,     MODE_A, 16'd1,     1'b0, '0}
    };

    two_cord_plotter_kinematics_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint root_floor(longint v);
        longint r;
        longint t;
        r = 0;
        for (int i = 20; i >= 0; i--) begin
            t = r | (longint'(1) << i);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] clip_len(longint v);
        return (v > longint'(LEN_MAX)) ? LEN_MAX : LEN_W'(v);
    endfunction

    // apply one coordinate update to the shadow state, return the new position
    function automatic pen_pos_t advance_position(mode_t mode, logic [VAL_W-1:0] val);
        pen_pos_t p;
        longint   w;
        longint   xs;
        longint   yy;
        longint   dx;
        longint   aa;
        longint   bb;
        longint   q;
        logic     unr;
        w = longint'(plane_w);
        unr = 1'b0;
        case (mode)
            MODE_X: pen_x = X_W'(val);
            MODE_Y: pen_y = LEN_W'(val);
            MODE_A: cord_a_len = LEN_W'(val);
            default: cord_b_len = LEN_W'(val);
        endcase
        if (mode == MODE_X || mode == MODE_Y) begin
            xs = longint'(pen_x);
            yy = longint'(pen_y) * longint'(pen_y);
            dx = w - xs;
            cord_a_len = clip_len(root_floor(xs * xs + yy));
            cord_b_len = clip_len(root_floor(dx * dx + yy));
        end else begin
            aa = longint'(cord_a_len) * longint'(cord_a_len);
            bb = longint'(cord_b_len) * longint'(cord_b_len);
            q = (w == 0) ? 0 : (w * w + aa - bb) / (2 * w);
            if (q > longint'($signed(X_MAX))) begin
                q = longint'($signed(X_MAX));
            end
            if (q < longint'($signed(X_MIN))) begin
                q = longint'($signed(X_MIN));
            end
            pen_x = X_W'(q);
            if (aa < q * q) begin
                pen_y = '0;
                unr = 1'b1;
            end else begin
                pen_y = LEN_W'(root_floor(aa - q * q));
            end
        end
        p.x = pen_x;
        p.y = pen_y;
        p.a = cord_a_len;
        p.b = cord_b_len;
        p.unr = unr;
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end
        if (r < 95) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic mode_t pick_mode();
        return mode_t'(2'($urandom_range(0, 3)));
    endfunction

    // mix of full range, plausible cord lengths around the width, small and edge values
    function automatic logic [VAL_W-1:0] pick_value(logic [W_WIDTH-1:0] w);
        int lo;
        int hi;
        lo = w / 2;
        hi = (w > 32767) ? 65535 : 2 * w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VAL_W'($urandom_range(0, 65535));
            4, 5: return VAL_W'($urandom_range(lo, hi));
            6: return VAL_W'($urandom_range(0, 255));
            7: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return w;
                endcase
            end
            default: return VAL_W'($urandom >> $urandom_range(16, 31));
        endcase
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s, result %0d: got %0d, expected %0d",
                 field, positions_checked, got, want);
        mismatch_count++;
    endtask

    task automatic check_position();
        pen_pos_t want;
        if (expected_positions.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
            return;
        end
        want = expected_positions.pop_front();
        if (m_tdata[X_W-1:0] !== want.x) begin
            report_mismatch("pos_x", longint'($signed(m_tdata[X_W-1:0])), longint'(want.x));
        end
        if (m_tdata[Y_LSB +: LEN_W] !== want.y) begin
            report_mismatch("pos_y", longint'(m_tdata[Y_LSB +: LEN_W]), longint'(want.y));
        end
        if (m_tdata[A_LSB +: LEN_W] !== want.a) begin
            report_mismatch("cord_a", longint'(m_tdata[A_LSB +: LEN_W]), longint'(want.a));
        end
        if (m_tdata[B_LSB +: LEN_W] !== want.b) begin
            report_mismatch("cord_b", longint'(m_tdata[B_LSB +: LEN_W]), longint'(want.b));
        end
        if (m_tuser[0] !== want.unr) begin
            report_mismatch("unreachable", longint'(m_tuser[0]), longint'(want.unr));
        end
        if (m_tuser[0] === 1'b1) begin
            unreachable_seen++;
        end
        positions_checked++;
    endtask

    task automatic send_item(mode_t mode, logic [VAL_W-1:0] val, bit typed, pen_pos_t want);
        pen_pos_t p;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        p = advance_position(mode, val);
        expected_positions.push_back(typed ? want : p);
        positions_sent++;
    endtask

    task automatic sender_pause(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_positions.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // register writes only with the block drained
    task automatic write_plane_width(logic [W_WIDTH-1:0] w);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        plane_w = w;
        widths_used++;
        cfg_valid <= 1'b0;
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_position();
            end
            if (stall_left == 0) begin
                if (!long_hold_done && positions_checked >= HOLD_AFTER) begin
                    // long back-pressure so the block fills and stalls its input
                    long_hold_done = 1'b1;
                    stall_left = LONG_HOLD;
                end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_positions.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [W_WIDTH-1:0] phase_w;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_X;
        plane_w    = PLANE_WIDTH_RST;
        pen_x      = '0;
        pen_y      = '0;
        cord_a_len = '0;
        cord_b_len = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].new_w) begin
                write_plane_width(plan[i].w);
            end
            send_item(plan[i].mode, plan[i].val, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: phase_w = PLANE_WIDTH_RST;
                1: phase_w = 16'd16;
                2: phase_w = 16'hFFFF;
                3: phase_w = 16'd0;
                default: phase_w = W_WIDTH'($urandom_range(0, 65535));
            endcase
            write_plane_width(phase_w);
            tx_throttle = (ph % 3 != 2);
            rx_throttle = (ph % 4 != 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(pick_mode(), pick_value(phase_w), 1'b0, '0);
                if (tx_throttle && $urandom_range(0, 2) == 0) begin
                    sender_pause(pick_gap());
                end
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d coordinate updates sent, %0d positions checked, %0d width writes",
                 positions_sent, positions_checked, widths_used);
        $display("run: %0d unreachable positions seen, %0d mismatches, %0d left waiting",
                 unreachable_seen, mismatch_count, expected_positions.size());
        if (mismatch_count == 0 && expected_positions.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
